// ===== rtl/mrmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrmf_pkg
// shared constants, codes and the byte-wide crc-16 step for the modbus framer
// ----------------------------------------------------------------------------
package mrmf_pkg;

    localparam int MAX_REGS = 32;
    localparam int CNT_W    = 6;
    localparam int WIDX_W   = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int BYTES_W  = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FUNC_READ  = 8'h03;
    localparam logic [7:0]  FUNC_WRITE = 8'h06;

    // input operations
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_BYTE    = 2'd2;
    localparam logic [1:0] OP_TIMEOUT = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // transaction status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_EXCEPTION = 3'd2;
    localparam logic [2:0] ST_COUNT     = 3'd3;
    localparam logic [2:0] ST_CRC       = 3'd4;

    // reception phase
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_READ  = 2'd1;
    localparam logic [1:0] PH_WRITE = 2'd2;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/modbus_rtu_master_framer.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_master_framer: modbus rtu request framer and response checker
// request: 8 tx bytes, one per cycle unless out_ready stalls, sent from S_TX;
// response bytes are taken while idle; a good read then emits its words from
// the registered word store, then the status; async reset clears control
// ----------------------------------------------------------------------------
module modbus_rtu_master_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] address,
    input  logic [5:0]  count,
    input  logic [15:0] value,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] data,
    output logic [2:0]  status,
    output logic        last
);
    import mrmf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TX     = 3'd1;
    localparam logic [2:0] S_WORDS  = 3'd2;
    localparam logic [2:0] S_STATUS = 3'd3;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]   regs_reg, regs_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         held_reg, held_next;
    logic               exc_reg, exc_next;
    logic               mism_reg, mism_next;
    logic               is_read_reg, is_read_next;
    logic [15:0]        addr_reg, addr_next;
    logic [15:0]        fld_reg, fld_next;
    logic [2:0]         tx_idx_reg, tx_idx_next;
    logic [CNT_W-1:0]   widx_reg, widx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [2:0]         stat_reg, stat_next;
    logic [7:0]         slave_reg;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [15:0]        data_reg, data_next;
    logic [2:0]         status_reg, status_next;
    logic               last_reg, last_next;

    // word store
    logic [15:0]        word_mem [MAX_REGS];
    logic [15:0]        mem_rdata_reg;
    logic               mem_we, mem_re;
    logic [WIDX_W-1:0]  mem_waddr, mem_raddr;
    logic [15:0]        mem_wdata;

    logic               can_load;
    logic [CNT_W-1:0]   sat_cnt;
    logic [BYTES_W-1:0] exp_m2, exp_m1, bytes_inc, off;
    logic [7:0]         tx_byte;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign can_load  = !out_valid_reg || out_ready;

    assign sat_cnt   = (count > MAX_REGS[CNT_W-1:0]) ? MAX_REGS[CNT_W-1:0] : count;
    assign exp_m2    = BYTES_W'(3) + BYTES_W'({regs_reg, 1'b0});
    assign exp_m1    = exp_m2 + 1'b1;
    assign bytes_inc = bytes_reg + 1'b1;
    assign off       = bytes_reg - BYTES_W'(3);

    always_comb begin
        case (tx_idx_reg)
            3'd0:    tx_byte = slave_reg;
            3'd1:    tx_byte = is_read_reg ? FUNC_READ : FUNC_WRITE;
            3'd2:    tx_byte = addr_reg[15:8];
            3'd3:    tx_byte = addr_reg[7:0];
            3'd4:    tx_byte = fld_reg[15:8];
            3'd5:    tx_byte = fld_reg[7:0];
            3'd6:    tx_byte = crc_reg[7:0];
            default: tx_byte = crc_reg[15:8];
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        regs_next    = regs_reg;
        bytes_next   = bytes_reg;
        crc_next     = crc_reg;
        held_next    = held_reg;
        exc_next     = exc_reg;
        mism_next    = mism_reg;
        is_read_next = is_read_reg;
        addr_next    = addr_reg;
        fld_next     = fld_reg;
        tx_idx_next  = tx_idx_reg;
        widx_next    = widx_reg;
        rd_pend_next = rd_pend_reg;
        stat_next    = stat_reg;
        mem_we       = 1'b0;
        mem_waddr    = off[WIDX_W:1];
        mem_wdata    = {held_reg, rx_byte};
        mem_re       = 1'b0;
        mem_raddr    = widx_reg[WIDX_W-1:0];

        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    case (op)
                        OP_READ, OP_WRITE: begin
                            is_read_next = (op == OP_READ);
                            addr_next    = address;
                            fld_next     = (op == OP_READ) ?
                                           {{(16-CNT_W){1'b0}}, sat_cnt} : value;
                            regs_next    = (op == OP_READ) ? sat_cnt : '0;
                            phase_next   = (op == OP_READ) ? PH_READ : PH_WRITE;
                            bytes_next   = '0;
                            held_next    = '0;
                            exc_next     = 1'b0;
                            mism_next    = 1'b0;
                            crc_next     = CRC_INIT;
                            tx_idx_next  = '0;
                            state_next   = S_TX;
                        end
                        OP_BYTE: begin
                            if (phase_reg == PH_WRITE) begin
                                if (bytes_inc >= BYTES_W'(8)) begin
                                    stat_next  = ST_OK;
                                    bytes_next = '0;
                                    phase_next = PH_IDLE;
                                    state_next = S_STATUS;
                                end else begin
                                    bytes_next = bytes_inc;
                                end
                            end else if (phase_reg == PH_READ) begin
                                if (bytes_reg < exp_m2) begin
                                    crc_next   = crc_byte(crc_reg, rx_byte);
                                    bytes_next = bytes_inc;
                                    if (bytes_reg == BYTES_W'(1)) begin
                                        exc_next = rx_byte[7];
                                    end else if (bytes_reg == BYTES_W'(2)) begin
                                        mism_next = (rx_byte != 8'({regs_reg, 1'b0}));
                                    end else if (bytes_reg >= BYTES_W'(3)) begin
                                        // even offset holds the high byte, odd completes the word
                                        if (!off[0]) begin
                                            held_next = rx_byte;
                                        end else begin
                                            mem_we = 1'b1;
                                        end
                                    end
                                end else if (bytes_reg == exp_m2) begin
                                    held_next  = rx_byte;
                                    bytes_next = bytes_inc;
                                end else begin
                                    if (exc_reg) begin
                                        stat_next = ST_EXCEPTION;
                                    end else if (mism_reg) begin
                                        stat_next = ST_COUNT;
                                    end else if ({rx_byte, held_reg} != crc_reg) begin
                                        stat_next = ST_CRC;
                                    end else begin
                                        stat_next = ST_OK;
                                    end
                                    bytes_next = '0;
                                    crc_next   = CRC_INIT;
                                    held_next  = '0;
                                    exc_next   = 1'b0;
                                    mism_next  = 1'b0;
                                    phase_next = PH_IDLE;
                                    widx_next  = '0;
                                    rd_pend_next = 1'b0;
                                    if (!exc_reg && !mism_reg &&
                                        ({rx_byte, held_reg} == crc_reg) && (regs_reg != '0)) begin
                                        state_next = S_WORDS;
                                    end else begin
                                        state_next = S_STATUS;
                                    end
                                end
                            end
                        end
                        OP_TIMEOUT: begin
                            if (phase_reg != PH_IDLE) begin
                                stat_next  = ST_TIMEOUT;
                                bytes_next = '0;
                                crc_next   = CRC_INIT;
                                held_next  = '0;
                                exc_next   = 1'b0;
                                mism_next  = 1'b0;
                                phase_next = PH_IDLE;
                                state_next = S_STATUS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TX: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_TX;
                    data_next      = {8'h00, tx_byte};
                    status_next    = ST_OK;
                    last_next      = (tx_idx_reg == 3'd7);
                    tx_idx_next    = tx_idx_reg + 1'b1;
                    if (tx_idx_reg < 3'd6) begin
                        crc_next = crc_byte(crc_reg, tx_byte);
                    end
                    if (tx_idx_reg == 3'd7) begin
                        // reception starts from a fresh crc
                        crc_next   = CRC_INIT;
                        state_next = S_IDLE;
                    end
                end
            end
            S_WORDS: begin
                // words were all written during reception, no overlap with these reads
                if (!rd_pend_reg) begin
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                end else if (can_load) begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_WORD;
                    data_next      = mem_rdata_reg;
                    status_next    = ST_OK;
                    last_next      = 1'b0;
                    widx_next      = widx_reg + 1'b1;
                    rd_pend_next   = 1'b0;
                    if (widx_reg + 1'b1 == regs_reg) begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_STATUS: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STATUS;
                    data_next      = '0;
                    status_next    = stat_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            regs_reg      <= '0;
            bytes_reg     <= '0;
            crc_reg       <= CRC_INIT;
            held_reg      <= '0;
            exc_reg       <= 1'b0;
            mism_reg      <= 1'b0;
            tx_idx_reg    <= '0;
            widx_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            slave_reg     <= 8'd1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            regs_reg      <= regs_next;
            bytes_reg     <= bytes_next;
            crc_reg       <= crc_next;
            held_reg      <= held_next;
            exc_reg       <= exc_next;
            mism_reg      <= mism_next;
            tx_idx_reg    <= tx_idx_next;
            widx_reg      <= widx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                slave_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk) begin
        is_read_reg <= is_read_next;
        addr_reg    <= addr_next;
        fld_reg     <= fld_next;
        stat_reg    <= stat_next;
        kind_reg    <= kind_next;
        data_reg    <= data_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk) begin
        if (mem_we) begin
            word_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= word_mem[mem_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign last      = last_reg;

`ifndef SYNTH
    a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_WORD) |-> !last_reg)
        else $error("register word flagged as last result");

    a_words_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WORDS) |-> (phase_reg == PH_IDLE && widx_reg < regs_reg))
        else $error("word emission outside finished read");

    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WRITE) |-> (bytes_reg < BYTES_W'(8)))
        else $error("write response byte count overrun");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_READ) |-> (bytes_reg <= exp_m1))
        else $error("read response byte count overrun");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for modbus_rtu_master_framer
// drives requests, response bytes and timeouts through valid/ready channels,
// predicts every tx byte, register word and status, checks results in order
// ----------------------------------------------------------------------------
module testbench;

    import mrmf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_CYCLES  = 80;
    localparam logic [7:0]  EXCEPTION_FLAG = 8'h80;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data;
        logic [2:0]  status;
        logic        last;
    } engine_out_t;

    typedef enum {
        REPLY_GOOD,
        REPLY_EXCEPTION,
        REPLY_BAD_COUNT,
        REPLY_BAD_CRC,
        REPLY_TIMED_OUT,
        REPLY_ABANDONED
    } reply_shape_t;

    class modbus_scoreboard;
        logic [7:0]   slave_addr;
        logic [1:0]   phase;
        int unsigned  regs_req;
        int unsigned  rx_count;
        logic [15:0]  crc;
        logic [7:0]   held;
        bit           exc_seen;
        bit           count_bad;
        logic [15:0]  words [MAX_REGS];
        engine_out_t  due_results [$];
        int unsigned  mismatches;

        function new();
            slave_addr = 8'd1;
            phase      = PH_IDLE;
            regs_req   = 0;
            mismatches = 0;
            clear_rx();
        endfunction

        function void clear_rx();
            rx_count  = 0;
            crc       = CRC_INIT;
            held      = 8'h00;
            exc_seen  = 1'b0;
            count_bad = 1'b0;
        endfunction

        function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function void push(logic [1:0] k, logic [15:0] d, logic [2:0] s, logic l);
            engine_out_t r;
            r.kind   = k;
            r.data   = d;
            r.status = s;
            r.last   = l;
            due_results.push_back(r);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_config(logic [7:0] a);
            slave_addr = a;
        endfunction

        function void note_input(logic [1:0] op_i, logic [15:0] addr_i, logic [5:0] cnt_i,
                                 logic [15:0] val_i, logic [7:0] rx_i);
            logic [7:0]  frm [8];
            logic [15:0] c;
            logic [2:0]  verdict;
            int unsigned n, need, idx, w;
            n = (cnt_i > MAX_REGS) ? MAX_REGS : cnt_i;
            if (op_i == OP_READ || op_i == OP_WRITE)
            begin
                frm[0] = slave_addr;
                frm[1] = (op_i == OP_READ) ? FUNC_READ : FUNC_WRITE;
                frm[2] = addr_i[15:8];
                frm[3] = addr_i[7:0];
                frm[4] = (op_i == OP_READ) ? 8'h00 : val_i[15:8];
                frm[5] = (op_i == OP_READ) ? n[7:0] : val_i[7:0];
                c = CRC_INIT;
                for (int i = 0; i < 6; i++)
                    c = crc_update(c, frm[i]);
                frm[6] = c[7:0];
                frm[7] = c[15:8];
                for (int i = 0; i < 8; i++)
                    push(KIND_TX, {8'h00, frm[i]}, ST_OK, i == 7);
                regs_req = (op_i == OP_READ) ? n : 0;
                phase    = (op_i == OP_READ) ? PH_READ : PH_WRITE;
                clear_rx();
                return;
            end
            // bytes and timeouts with nothing pending are dropped
            if (phase == PH_IDLE)
                return;
            if (op_i == OP_TIMEOUT)
            begin
                push(KIND_STATUS, 16'h0000, ST_TIMEOUT, 1'b1);
                phase = PH_IDLE;
                clear_rx();
                return;
            end
            if (phase == PH_WRITE)
            begin
                rx_count++;
                if (rx_count >= 8)
                begin
                    push(KIND_STATUS, 16'h0000, ST_OK, 1'b1);
                    phase = PH_IDLE;
                    clear_rx();
                end
                return;
            end
            need = 5 + 2 * regs_req;
            idx  = rx_count;
            if (idx < need - 2)
            begin
                crc = crc_update(crc, rx_i);
                if (idx == 1)
                    exc_seen = (rx_i & EXCEPTION_FLAG) != 0;
                else if (idx == 2)
                    count_bad = rx_i != 8'(2 * regs_req);
                else if (idx >= 3)
                begin
                    w = (idx - 3) >> 1;
                    if (((idx - 3) & 1) == 0)
                        held = rx_i;
                    else if (w < MAX_REGS)
                        words[w] = {held, rx_i};
                end
                rx_count = idx + 1;
                return;
            end
            if (idx == need - 2)
            begin
                held     = rx_i;
                rx_count = idx + 1;
                return;
            end
            if (exc_seen)
                verdict = ST_EXCEPTION;
            else if (count_bad)
                verdict = ST_COUNT;
            else if ({rx_i, held} != crc)
                verdict = ST_CRC;
            else
                verdict = ST_OK;
            if (verdict == ST_OK)
                for (int i = 0; i < regs_req && i < MAX_REGS; i++)
                    push(KIND_WORD, words[i], ST_OK, 1'b0);
            push(KIND_STATUS, 16'h0000, verdict, 1'b1);
            phase = PH_IDLE;
            clear_rx();
        endfunction

        function void check_result(logic [1:0] k, logic [15:0] d, logic [2:0] s, logic l);
            engine_out_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d data %h status %0d last %0b",
                             k, d, s, l);
                return;
            end
            want = due_results.pop_front();
            if (want.kind !== k || want.data !== d || want.status !== s || want.last !== l)
            begin
                mismatches++;
                // values in the order kind, data, status, last
                if (mismatches <= 10)
                    $display("mismatch: got %0d %h %0d %0b, expected %0d %h %0d %0b",
                             k, d, s, l, want.kind, want.data, want.status, want.last);
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  op        = OP_READ;
    logic [15:0] address   = 16'h0000;
    logic [5:0]  count     = 6'd0;
    logic [15:0] value     = 16'h0000;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [15:0] data;
    logic [2:0]  status;
    logic        last;

    modbus_scoreboard sb;
    bit          in_idling  = 1'b1;
    bit          out_idling = 1'b1;
    int          fed        = 0;
    int          quiet_cycles = 0;

    modbus_rtu_master_framer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .address   (address),
        .count     (count),
        .value     (value),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data      (data),
        .status    (status),
        .last      (last)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        if (out_idling)
            out_ready = ($urandom_range(99) >= 30);
        else
            out_ready = 1'b1;
    end

    // every transaction is recorded at the edge where it happens
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(kind, data, status, last);
            if (cfg_valid && cfg_ready)
                sb.note_config(cfg_data);
            if (in_valid && in_ready)
                sb.note_input(op, address, count, value, rx_byte);
            if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] op_i, logic [15:0] addr_i, logic [5:0] cnt_i,
                             logic [15:0] val_i, logic [7:0] rx_i, bit counted);
        @(negedge clk);
        while (in_idling && $urandom_range(99) < 30)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        op       = op_i;
        address  = addr_i;
        count    = cnt_i;
        value    = val_i;
        rx_byte  = rx_i;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        if (counted)
            fed++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(OP_BYTE, 16'($urandom), 6'($urandom), 16'($urandom), b, 1'b1);
    endtask

    task automatic send_timeout();
        send_item(OP_TIMEOUT, 16'($urandom), 6'($urandom), 16'($urandom), 8'($urandom), 1'b1);
    endtask

    // hold the sender off until every result is in and the engine is quiet
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_slave(logic [7:0] a);
        send_timeout();
        settle();
        @(negedge clk);
        cfg_data  = a;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic answer_read(logic [5:0] cnt_req, reply_shape_t shape);
        logic [7:0]  frm [$];
        logic [15:0] c;
        int unsigned n, cut, pos;
        n = (cnt_req > MAX_REGS) ? MAX_REGS : cnt_req;
        frm.push_back(8'($urandom));
        if (shape == REPLY_EXCEPTION)
            frm.push_back(EXCEPTION_FLAG | 8'($urandom_range(0, 127)));
        else
            frm.push_back(FUNC_READ);
        if (shape == REPLY_BAD_COUNT)
            frm.push_back(8'(2 * n) ^ 8'($urandom_range(1, 255)));
        else
            frm.push_back(8'(2 * n));
        repeat (2 * n) frm.push_back(8'($urandom));
        c = CRC_INIT;
        foreach (frm[i])
            c = sb.crc_update(c, frm[i]);
        frm.push_back(c[7:0]);
        frm.push_back(c[15:8]);
        if (shape == REPLY_BAD_CRC)
        begin
            pos = frm.size() - 1 - $urandom_range(0, 1);
            frm[pos] = frm[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        cut = frm.size();
        if (shape == REPLY_TIMED_OUT || shape == REPLY_ABANDONED)
            cut = $urandom_range(0, frm.size() - 1);
        for (int i = 0; i < cut; i++)
            send_byte(frm[i]);
        if (shape == REPLY_TIMED_OUT)
            send_timeout();
    endtask

    task automatic answer_write(reply_shape_t shape);
        int unsigned cut;
        cut = 8;
        if (shape == REPLY_TIMED_OUT || shape == REPLY_ABANDONED)
            cut = $urandom_range(0, 7);
        repeat (cut) send_byte(8'($urandom));
        if (shape == REPLY_TIMED_OUT)
            send_timeout();
    endtask

    function automatic reply_shape_t pick_shape();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return REPLY_GOOD;
        else if (r < 68)
            return REPLY_EXCEPTION;
        else if (r < 76)
            return REPLY_BAD_COUNT;
        else if (r < 86)
            return REPLY_BAD_CRC;
        else if (r < 93)
            return REPLY_TIMED_OUT;
        return REPLY_ABANDONED;
    endfunction

    task automatic run_traffic(int target);
        int          stop;
        int unsigned r;
        logic [5:0]  cnt;
        logic [1:0]  noise_op;
        stop = fed + target;
        while (fed < stop)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                // mostly short reads, now and then the full count range
                cnt = ($urandom_range(9) < 9) ? 6'($urandom_range(0, 4)) : 6'($urandom);
                send_item(OP_READ, 16'($urandom), cnt, 16'($urandom), 8'($urandom), 1'b1);
                answer_read(cnt, pick_shape());
            end
            else if (r < 80)
            begin
                send_item(OP_WRITE, 16'($urandom), 6'($urandom), 16'($urandom),
                          8'($urandom), 1'b1);
                answer_write(($urandom_range(99) < 80) ? REPLY_GOOD : pick_shape());
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    noise_op = 2'($urandom);
                    send_item(noise_op, 16'($urandom), 6'($urandom), 16'($urandom),
                              8'($urandom), noise_op == OP_READ || noise_op == OP_WRITE);
                end
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_slave(8'd1);

        // nothing pending: byte and timeout are dropped
        send_item(OP_BYTE, 16'hFFFF, 6'h3F, 16'hFFFF, 8'hFF, 1'b0);
        send_item(OP_TIMEOUT, 16'h0000, 6'h00, 16'h0000, 8'h00, 1'b0);
        // zero-count read, five byte reply
        send_item(OP_READ, 16'h0000, 6'd0, 16'h0000, 8'h00, 1'b1);
        answer_read(6'd0, REPLY_GOOD);
        // write single at the top of both ranges
        send_item(OP_WRITE, 16'hFFFF, 6'h3F, 16'hFFFF, 8'hFF, 1'b1);
        answer_write(REPLY_GOOD);
        // count above the store size is clipped, then the reply times out
        send_item(OP_READ, 16'hFFFF, 6'h3F, 16'h0000, 8'h00, 1'b1);
        send_timeout();
        // a new request drops the pending read
        send_item(OP_READ, 16'h00FF, 6'd33, 16'h5A5A, 8'hA5, 1'b1);
        send_item(OP_WRITE, 16'hFF00, 6'd1, 16'h0000, 8'h00, 1'b1);
        send_timeout();

        set_slave(8'd247);
        run_traffic(12);
        set_slave(8'($urandom_range(2, 246)));
        run_traffic(12);
        // long stretch with both sides at full rate
        in_idling  = 1'b0;
        out_idling = 1'b0;
        set_slave(8'd1);
        run_traffic(20);
        in_idling  = 1'b1;
        out_idling = 1'b1;
        set_slave(8'($urandom_range(1, 247)));
        run_traffic(12);

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
